/* design/psp_pkg.sv */
// Shared types and constants for the particle slot pool.
// Used by psp_ctrl and particle_slot_pool; depends on nothing.
package psp_pkg;

    localparam int SLOTS   = 1024;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int CNT_W   = 11;
    localparam int TIME_W  = 24;
    localparam int DELTA_W = 16;
    localparam int AGE_RAM_W = 2 * TIME_W;

    localparam logic [PTR_W-1:0]  NONE    = PTR_W'(SLOTS);
    localparam logic [PTR_W-1:0]  LAST_IX = PTR_W'(SLOTS - 1);
    localparam logic [TIME_W-1:0] AGE_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        OP_SPAWN = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SPAWN,
        S_WALK,
        S_WALK_END,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic [TIME_W-1:0]  life_ms;
        logic [DELTA_W-1:0] delta_ms;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  retired;
        logic [CNT_W-1:0]  live;
    } t_res;

endpackage

/* design/psp_ram.sv */
// Generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered (old data on a same-address write).
module psp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/psp_ctrl.sv */
// Sequencer for the slot pool: owns the link RAM and the age/span RAM and
// runs spawn, tick walk, clear and the post-reset link sweep. Uses psp_pkg, psp_ram.
module psp_ctrl
    import psp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    t_state r_state, n_state;

    logic [PTR_W-1:0]   r_free_head, n_free_head;
    logic [PTR_W-1:0]   r_live_head, n_live_head;
    logic [CNT_W-1:0]   r_live_cnt,  n_live_cnt;
    logic [PTR_W-1:0]   r_ptr,       n_ptr;
    logic [PTR_W-1:0]   r_first,     n_first;
    logic [PTR_W-1:0]   r_last,      n_last;
    logic [CNT_W-1:0]   r_kept,      n_kept;
    logic [CNT_W-1:0]   r_retired,   n_retired;
    logic [PTR_W-1:0]   r_visits,    n_visits;
    logic [TIME_W-1:0]  r_life,      n_life;
    logic [DELTA_W-1:0] r_delta,     n_delta;
    t_res               r_res,       n_res;

    logic                 link_we;
    logic [SLOT_W-1:0]    link_waddr, link_raddr;
    logic [PTR_W-1:0]     link_wdata, link_rdata;
    logic                 age_we;
    logic [SLOT_W-1:0]    age_waddr, age_raddr;
    logic [AGE_RAM_W-1:0] age_wdata, age_rdata;

    logic [TIME_W-1:0] cur_age, cur_span, new_age;
    logic [TIME_W:0]   age_sum;
    logic              expire;

    psp_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    psp_ram #(.WIDTH(AGE_RAM_W), .DEPTH(SLOTS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (age_raddr),
        .o_rdata (age_rdata)
    );

    // Age update of the slot under the walk pointer, saturating.
    assign cur_span = age_rdata[AGE_RAM_W-1:TIME_W];
    assign cur_age  = age_rdata[TIME_W-1:0];
    assign age_sum  = {1'b0, cur_age} + (TIME_W+1)'(r_delta);
    assign new_age  = age_sum[TIME_W] ? AGE_MAX : age_sum[TIME_W-1:0];
    assign expire   = new_age > cur_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_free_head <= '0;
            r_live_head <= NONE;
            r_live_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_free_head <= n_free_head;
            r_live_head <= n_live_head;
            r_live_cnt  <= n_live_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first   <= n_first;
        r_last    <= n_last;
        r_kept    <= n_kept;
        r_retired <= n_retired;
        r_visits  <= n_visits;
        r_life    <= n_life;
        r_delta   <= n_delta;
        r_res     <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_live_head = r_live_head;
        n_live_cnt  = r_live_cnt;
        n_ptr       = r_ptr;
        n_first     = r_first;
        n_last      = r_last;
        n_kept      = r_kept;
        n_retired   = r_retired;
        n_visits    = r_visits;
        n_life      = r_life;
        n_delta     = r_delta;
        n_res       = r_res;

        link_we    = 1'b0;
        link_waddr = r_ptr[SLOT_W-1:0];
        link_wdata = r_ptr + PTR_W'(1);
        link_raddr = r_ptr[SLOT_W-1:0];
        age_we     = 1'b0;
        age_waddr  = r_ptr[SLOT_W-1:0];
        age_wdata  = {r_life, {TIME_W{1'b0}}};
        age_raddr  = r_ptr[SLOT_W-1:0];

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            S_INIT, S_CLEAR: begin
                // Rebuild the free chain: slot i links to i+1, the last to none.
                link_we = 1'b1;
                n_ptr   = r_ptr + PTR_W'(1);
                if (r_ptr == LAST_IX) begin
                    n_free_head = '0;
                    n_live_head = NONE;
                    n_live_cnt  = '0;
                    n_res       = '{ok: 1'b1, slot: '0, retired: '0, live: '0};
                    n_state     = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                n_life      = i_req.life_ms;
                n_delta     = i_req.delta_ms;
                n_ptr       = '0;
                n_first     = NONE;
                n_last      = NONE;
                n_kept      = '0;
                n_retired   = '0;
                n_visits    = '0;
                if (i_req_valid) begin
                    case (i_req.op)
                        OP_SPAWN: begin
                            if (r_free_head == NONE) begin
                                n_res   = '{ok: 1'b0, slot: '0, retired: '0,
                                            live: r_live_cnt};
                                n_state = S_DONE;
                            end else begin
                                n_ptr   = r_free_head;
                                n_state = S_SPAWN;
                            end
                        end
                        OP_TICK: begin
                            if (r_live_head == NONE) begin
                                n_live_cnt = '0;
                                n_res      = '{ok: 1'b1, slot: '0, retired: '0,
                                               live: '0};
                                n_state    = S_DONE;
                            end else begin
                                n_ptr   = r_live_head;
                                n_state = S_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_res   = '{ok: 1'b0, slot: '0, retired: '0,
                                        live: r_live_cnt};
                            n_state = S_DONE;
                        end
                    endcase
                    link_raddr = n_ptr[SLOT_W-1:0];
                    age_raddr  = n_ptr[SLOT_W-1:0];
                end
            end
            S_SPAWN: begin
                // link_rdata is the next free slot after the popped head.
                n_free_head = link_rdata;
                link_we     = 1'b1;
                link_wdata  = r_live_head;
                age_we      = 1'b1;
                n_live_head = r_ptr;
                n_live_cnt  = r_live_cnt + CNT_W'(1);
                n_res       = '{ok: 1'b1, slot: r_ptr[SLOT_W-1:0], retired: '0,
                                live: r_live_cnt + CNT_W'(1)};
                n_state     = S_DONE;
            end
            S_WALK: begin
                age_we    = 1'b1;
                age_wdata = {cur_span, new_age};
                n_visits  = r_visits + PTR_W'(1);
                if (expire) begin
                    link_we     = 1'b1;
                    link_wdata  = r_free_head;
                    n_free_head = r_ptr;
                    n_retired   = r_retired + CNT_W'(1);
                end else begin
                    // Survivor: chain it behind the previous survivor; its own
                    // link is closed when the walk ends or the next survivor lands.
                    if (r_last != NONE) begin
                        link_we    = 1'b1;
                        link_waddr = r_last[SLOT_W-1:0];
                        link_wdata = r_ptr;
                    end else begin
                        n_first = r_ptr;
                    end
                    n_last = r_ptr;
                    n_kept = r_kept + CNT_W'(1);
                end
                if (link_rdata == NONE || r_visits == LAST_IX) begin
                    n_state = S_WALK_END;
                end else begin
                    n_ptr      = link_rdata;
                    link_raddr = link_rdata[SLOT_W-1:0];
                    age_raddr  = link_rdata[SLOT_W-1:0];
                end
            end
            S_WALK_END: begin
                if (r_last != NONE) begin
                    link_we    = 1'b1;
                    link_waddr = r_last[SLOT_W-1:0];
                    link_wdata = NONE;
                end
                n_live_head = r_first;
                n_live_cnt  = r_kept;
                n_res       = '{ok: 1'b1, slot: '0, retired: r_retired, live: r_kept};
                n_state     = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

/* design/particle_slot_pool.sv */
// Top level of the particle slot pool: stream ports, request decode and the
// result output register. Uses psp_pkg and psp_ctrl.
//
// The pool holds 1024 particle slots split between a LIFO free list and an
// ordered live list, both threaded through one link RAM, with each slot's age
// and lifespan in a second RAM. Each request on the slave stream carries an
// operation in tuser (0 spawn, 1 tick, 2 clear) and returns exactly one result
// on the master stream. A spawn does one link RAM read, then one write-back,
// before its result is valid. A tick walks the live list one slot per cycle;
// the walk is bound by the single read port of the link RAM, whose read data
// names the next slot to fetch. A clear rewrites the whole link RAM, one entry
// per cycle. After reset the same sweep runs before tready first rises. The
// result sits in an output register, so the next request can be accepted while
// the previous result still waits for downstream tready.
module particle_slot_pool
    import psp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // life_ms[23:0], delta_ms[39:24]
    input  logic [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // slot[9:0], retired[20:10], live[31:21]
    output logic        o_m_axis_tuser   // ok[0]
);

    t_req req;
    t_res ctrl_res;
    logic ctrl_res_valid;
    logic res_ready;
    logic req_ready;

    logic r_out_valid;
    t_res r_out;

    // Unpack the request fields from the stream payload.
    assign req.op       = i_s_axis_tuser;
    assign req.life_ms  = i_s_axis_tdata[TIME_W-1:0];
    assign req.delta_ms = i_s_axis_tdata[TIME_W+DELTA_W-1:TIME_W];

    psp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_res_valid (ctrl_res_valid),
        .i_res_ready (res_ready),
        .o_res       (ctrl_res)
    );

    assign o_s_axis_tready = req_ready;

    // The output register takes a new result when it is empty or being drained.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= ctrl_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && ctrl_res_valid) begin
            r_out <= ctrl_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.ok;
    assign o_m_axis_tdata  = {r_out.live, r_out.retired, r_out.slot};

    // The link sweep after reset keeps the input closed.
    a_init_closed: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_s_axis_tready)
        else $error("request accepted before the link sweep finished");

    // A failed or ignored request never reports a slot or retirements.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[9:0] == 10'd0 && o_m_axis_tdata[20:10] == 11'd0)
        else $error("failed result carries slot or retired count");

    // Survivors plus retired slots of one tick never exceed the pool.
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ({1'b0, o_m_axis_tdata[31:21]} + {1'b0, o_m_axis_tdata[20:10]})
                <= 12'(SLOTS))
        else $error("live plus retired count exceeds the pool size");

    // A result handed to the output register frees the sequencer for a request.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_res_valid && res_ready |=> req_ready)
        else $error("sequencer did not return to idle after its result");

endmodule
